FILE: hdl/bpa_pkg.sv
package bpa_pkg;

	localparam int MAX_PAGES_DEF = 4096;
	localparam int WORD_BITS_DEF = 64;

	localparam int PAGE_COUNT_W = 13;
	localparam int PAGE_ID_W    = 12;
	localparam int STATUS_W     = 2;

	localparam logic [PAGE_COUNT_W-1:0] PAGE_COUNT_RST = 13'd4096;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_RANGE = 2'd2
	} status_t;

endpackage

FILE: hdl/bitmap_page_allocator.sv
// Bitmap page allocator: one used bit per page, held in a single-port-read,
// single-port-write synchronous RAM of MAX_PAGES/WORD_BITS words (WORD_BITS
// must be a power of two), plus a next-free hint. An allocate beat searches
// upward from the hint for the first clear bit below the effective page count
// (page_count, capped at MAX_PAGES); it never wraps, sets the bit, returns the
// page and moves the hint one past it, or reports STATUS_FULL. A free beat
// clears the page's bit, moves the hint to it and returns it, or reports
// STATUS_RANGE with page number zero when the page is at or above the count.
// Steps: a free beat goes through accept/read, modify and write back, and
// result load once the output register is free; an allocate beat likewise,
// but also reads extra bitmap words after the one holding the hint, one word
// per cycle through the RAM read port, until it finds a clear bit or reaches
// the count. One beat is worked on at a time; the next is accepted while the
// previous result still waits in the output register. After reset the RAM is
// cleared word by word with in_ready low; page_count writes are taken
// throughout and must only be issued while the block is idle.
module bitmap_page_allocator import bpa_pkg::*; #(
	parameter int MAX_PAGES = MAX_PAGES_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [PAGE_COUNT_W-1:0] cfg_wr_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    mode,
	input  logic [PAGE_ID_W-1:0]    page_id,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [PAGE_ID_W-1:0]    page_number,
	output logic [STATUS_W-1:0]     status
);

	localparam int NUM_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int BW        = $clog2(WORD_BITS);
	localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int PW        = $clog2(MAX_PAGES) + 1;
	// page numbers, hint and count share one width wide enough for all
	localparam int CW        = (PW > PAGE_COUNT_W) ? PW : PAGE_COUNT_W;
	localparam int WI_W      = CW - BW;
	localparam logic [CW-1:0] MAX_C     = CW'(MAX_PAGES);
	localparam logic [AW-1:0] LAST_WORD = AW'(NUM_WORDS - 1);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_DONE
	} state_t;

	state_t                  state_q;
	logic [AW-1:0]           clr_q;
	logic [PAGE_COUNT_W-1:0] page_count_q;
	logic [CW-1:0]           hint_q;
	logic                    mode_q;
	logic [CW-1:0]           p_q;          // page under examination
	logic [CW-1:0]           res_page_q;
	status_t                 res_status_q;
	logic                    out_valid_q;
	logic [PAGE_ID_W-1:0]    page_number_q;
	status_t                 status_q;

	// bitmap RAM
	logic [WORD_BITS-1:0] mem_q [NUM_WORDS];
	logic [WORD_BITS-1:0] rd_data_q;
	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [WORD_BITS-1:0] wr_data;

	// search and update
	logic [CW-1:0]        pc_ext;
	logic [CW-1:0]        eff_count;
	logic [CW-1:0]        pid_ext;
	logic                 in_acc;
	logic                 out_free;
	logic [WI_W-1:0]      wi;
	logic [BW-1:0]        bi;
	logic [WORD_BITS-1:0] bit_b;
	logic [WORD_BITS-1:0] cand;
	logic                 found;
	logic [BW-1:0]        idx;
	logic [WORD_BITS-1:0] bit_idx;
	logic [CW-1:0]        hit_page;
	logic [WI_W-1:0]      next_wi;
	logic [CW-1:0]        next_page;
	logic                 look_done;
	status_t              look_status;
	logic [CW-1:0]        look_page;
	logic                 hint_upd;
	logic [CW-1:0]        hint_nxt;

	assign pc_ext    = CW'(page_count_q);
	assign eff_count = (pc_ext > MAX_C) ? MAX_C : pc_ext;
	assign pid_ext   = CW'(page_id);

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	assign wi        = p_q[CW-1:BW];
	assign bi        = p_q[BW-1:0];
	assign bit_b     = {{(WORD_BITS-1){1'b0}}, 1'b1} << bi;
	// clear bits at or above the start bit of this word
	assign cand      = ~rd_data_q & ({WORD_BITS{1'b1}} << bi);
	assign bit_idx   = {{(WORD_BITS-1){1'b0}}, 1'b1} << idx;
	assign hit_page  = {wi, idx};
	assign next_wi   = wi + 1'b1;
	assign next_page = {next_wi, {BW{1'b0}}};

	// lowest clear bit
	always_comb begin
		found = 1'b0;
		idx   = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (cand[i]) begin
				found = 1'b1;
				idx   = BW'(i);
			end
		end
	end

	// decide one word of the search, or the free, and drive the RAM ports
	always_comb begin
		rd_en       = 1'b0;
		rd_addr     = hint_q[BW +: AW];
		wr_en       = 1'b0;
		wr_addr     = wi[AW-1:0];
		wr_data     = rd_data_q;
		look_done   = 1'b0;
		look_status = STATUS_OK;
		look_page   = '0;
		hint_upd    = 1'b0;
		hint_nxt    = hint_q;

		unique case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			S_IDLE: begin
				rd_en   = in_acc;
				rd_addr = (mode == MODE_FREE) ? pid_ext[BW +: AW] : hint_q[BW +: AW];
			end
			S_LOOK: begin
				if (mode_q == MODE_FREE) begin
					look_done = 1'b1;
					if (p_q < eff_count) begin
						wr_en     = 1'b1;
						wr_data   = rd_data_q & ~bit_b;
						look_page = p_q;
						hint_upd  = 1'b1;
						hint_nxt  = p_q;
					end else begin
						look_status = STATUS_RANGE;
					end
				end else if (p_q >= eff_count) begin
					look_done   = 1'b1;
					look_status = STATUS_FULL;
				end else if (found) begin
					look_done = 1'b1;
					if (hit_page < eff_count) begin
						wr_en     = 1'b1;
						wr_data   = rd_data_q | bit_idx;
						look_page = hit_page;
						hint_upd  = 1'b1;
						hint_nxt  = hit_page + 1'b1;
					end else begin
						look_status = STATUS_FULL;
					end
				end else if (next_page >= eff_count) begin
					look_done   = 1'b1;
					look_status = STATUS_FULL;
				end else begin
					// word full from the start bit: advance to the next word
					rd_en   = 1'b1;
					rd_addr = next_wi[AW-1:0];
				end
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_q         <= '0;
			page_count_q  <= PAGE_COUNT_RST;
			hint_q        <= '0;
			mode_q        <= MODE_ALLOC;
			p_q           <= '0;
			res_page_q    <= '0;
			res_status_q  <= STATUS_OK;
			out_valid_q   <= 1'b0;
			page_number_q <= '0;
			status_q      <= STATUS_OK;
		end else begin
			if (cfg_wr_en) begin
				page_count_q <= cfg_wr_data;
			end
			// drop the result once the consumer takes it, unless a new one follows
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_WORD) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						mode_q  <= mode;
						p_q     <= (mode == MODE_FREE) ? pid_ext : hint_q;
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					if (look_done) begin
						res_page_q   <= look_page;
						res_status_q <= look_status;
						state_q      <= S_DONE;
					end else begin
						p_q <= next_page;
					end
					if (hint_upd) begin
						hint_q <= hint_nxt;
					end
				end
				S_DONE: begin
					// hold the result until the output register is free
					if (out_free) begin
						out_valid_q   <= 1'b1;
						page_number_q <= res_page_q[PAGE_ID_W-1:0];
						status_q      <= res_status_q;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign page_number = page_number_q;
	assign status      = status_q;

endmodule

FILE: verif/tb_bitmap_page_allocator.sv
module tb_bitmap_page_allocator;
	import bpa_pkg::*;

	// One expected beat on the result side: the page number and the status code.
	typedef struct packed {
		logic [PAGE_ID_W-1:0] page;
		status_t              st;
	} page_result_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_wr_en;
	logic [PAGE_COUNT_W-1:0] cfg_wr_data;
	logic                    in_valid;
	logic                    in_ready;
	logic                    mode;
	logic [PAGE_ID_W-1:0]    page_id;
	logic                    out_valid;
	logic                    out_ready;
	logic [PAGE_ID_W-1:0]    page_number;
	logic [STATUS_W-1:0]     status;

	// Shadow copy of the allocator: used bits, next-free hint and page count.
	logic [WORD_BITS_DEF-1:0] used_map [MAX_PAGES_DEF/WORD_BITS_DEF];
	logic [PAGE_COUNT_W-1:0]  next_hint;
	logic [PAGE_COUNT_W-1:0]  page_count_m;

	// Results still owed by the block, oldest first.
	page_result_t awaited_results[$];

	int mismatches;
	int n_alloc_ok;
	int n_full;
	int n_free_ok;
	int n_range;
	int n_results;

	// Idling switches for the two sides; cleared for the calm phases.
	bit in_idle_on;
	bit out_idle_on;

	bitmap_page_allocator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.page_id    (page_id),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.page_number(page_number),
		.status     (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs; well beyond the slowest legal run.
	initial begin
		#8000000;
		$display("Timeout: %0d results still awaited", awaited_results.size());
		$display("Mismatches found");
		$finish;
	end

	// Effective page count: anything above the bitmap size is capped.
	function automatic int live_pages();
		return (page_count_m > MAX_PAGES_DEF) ? MAX_PAGES_DEF : int'(page_count_m);
	endfunction

	// Work out the result of one accepted beat and advance the shadow state.
	function automatic page_result_t predict_page_op(logic m, logic [PAGE_ID_W-1:0] pid);
		page_result_t r;
		int lim;
		int p;
		int w;
		bit hit;
		lim = live_pages();
		r.page = '0;
		r.st = STATUS_OK;
		hit = 1'b0;
		w = 0;
		if (m == MODE_ALLOC) begin
			// Scan upward from the hint, jumping over words with no clear bit; no wrap.
			p = int'(next_hint);
			while (p < lim && !hit) begin
				w = p / WORD_BITS_DEF;
				if (&used_map[w])
					p = (w + 1) * WORD_BITS_DEF;
				else if (!used_map[w][p % WORD_BITS_DEF])
					hit = 1'b1;
				else
					p++;
			end
			if (hit) begin
				used_map[w][p % WORD_BITS_DEF] = 1'b1;
				next_hint = PAGE_COUNT_W'(p + 1);
				r.page = PAGE_ID_W'(p);
				n_alloc_ok++;
			end else begin
				// Full, or hint already at or past the count: state untouched.
				r.st = STATUS_FULL;
				n_full++;
			end
		end else if (int'(pid) < lim) begin
			// Freeing an already free page is still fine; the hint follows the page.
			used_map[pid / WORD_BITS_DEF][pid % WORD_BITS_DEF] = 1'b0;
			next_hint = PAGE_COUNT_W'(pid);
			r.page = pid;
			n_free_ok++;
		end else begin
			r.st = STATUS_RANGE;
			n_range++;
		end
		return r;
	endfunction

	task automatic note_mismatch(string what, int want, int got);
		mismatches++;
		if (mismatches <= 10)
			$display("MISMATCH %0t: %s expected %0d got %0d", $realtime, what, want, got);
	endtask

	// Offer one request beat, hold it until taken, then record what it must return.
	task automatic issue_request(input logic m, input logic [PAGE_ID_W-1:0] pid);
		page_result_t r;
		while (in_idle_on && $urandom_range(99) < 6) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		mode = m;
		page_id = pid;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		r = predict_page_op(m, pid);
		awaited_results.push_back(r);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// Drain every outstanding result and let the pipeline settle.
	task automatic wait_quiet();
		while (awaited_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Change the page count only when the block has nothing in flight.
	task automatic write_page_count(input logic [PAGE_COUNT_W-1:0] v);
		wait_quiet();
		cfg_wr_en = 1'b1;
		cfg_wr_data = v;
		page_count_m = v;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// Pick a page to free: mostly near the live range, sometimes anywhere.
	function automatic logic [PAGE_ID_W-1:0] pick_free_page();
		int hi;
		hi = live_pages() + 4;
		if (hi > MAX_PAGES_DEF - 1)
			hi = MAX_PAGES_DEF - 1;
		if ($urandom_range(99) < 70)
			return PAGE_ID_W'($urandom_range(hi, 0));
		return PAGE_ID_W'($urandom);
	endfunction

	// Default count after reset: first-fit order, hint follows frees, runs off the top.
	task automatic test_after_reset();
		issue_request(MODE_ALLOC, 12'hfff);
		issue_request(MODE_ALLOC, 12'h000);
		issue_request(MODE_ALLOC, 12'h5a5);
		issue_request(MODE_FREE, 12'd1);
		issue_request(MODE_ALLOC, 12'ha5a);
		issue_request(MODE_ALLOC, 12'd0);
		issue_request(MODE_FREE, 12'd4095);
		issue_request(MODE_ALLOC, 12'd0);
		// hint now sits at the page count: allocate must report full
		issue_request(MODE_ALLOC, 12'd0);
		issue_request(MODE_FREE, 12'd0);
	endtask

	// Count at zero, one, just below the maximum, and above the maximum.
	task automatic test_count_extremes();
		write_page_count(13'd0);
		issue_request(MODE_ALLOC, 12'd0);
		issue_request(MODE_FREE, 12'd0);
		issue_request(MODE_FREE, 12'd4095);
		write_page_count(13'd1);
		issue_request(MODE_ALLOC, 12'd0);
		issue_request(MODE_ALLOC, 12'd0);
		issue_request(MODE_FREE, 12'd1);
		issue_request(MODE_FREE, 12'd0);
		write_page_count(13'd4095);
		issue_request(MODE_FREE, 12'd4095);
		issue_request(MODE_FREE, 12'd4094);
		write_page_count(13'h1fff);
		issue_request(MODE_FREE, 12'd2048);
		issue_request(MODE_ALLOC, 12'd0);
		issue_request(MODE_FREE, 12'd4095);
	endtask

	// Phases of mixed traffic; mostly small counts so words fill up and the search skips them.
	task automatic test_random_traffic();
		int ph;
		int i;
		int alloc_pct;
		logic [PAGE_COUNT_W-1:0] cnt;
		for (ph = 0; ph < 13; ph++) begin
			case (ph)
				3: cnt = 13'd4096;
				6: cnt = 13'h1fff;
				9: cnt = 13'd0;
				11: cnt = 13'd4095;
				12: cnt = PAGE_COUNT_W'($urandom_range(8191, 0));
				default: cnt = PAGE_COUNT_W'($urandom_range(300, 1));
			endcase
			write_page_count(cnt);
			// alternate filling and draining so both full and free paths get exercised
			alloc_pct = (ph % 2 == 0) ? 80 : 35;
			in_idle_on = !(ph == 4 || ph == 5);
			out_idle_on = in_idle_on;
			for (i = 0; i < 150; i++) begin
				if ($urandom_range(99) < alloc_pct)
					issue_request(MODE_ALLOC, PAGE_ID_W'($urandom));
				else
					issue_request(MODE_FREE, pick_free_page());
			end
		end
		in_idle_on = 1'b1;
		out_idle_on = 1'b1;
	endtask

	// Receiver: stall now and then, change only on the falling edge.
	always @(negedge clk)
		out_ready = !out_idle_on || ($urandom_range(99) >= 6);

	// Compare every accepted result beat against the oldest expectation.
	always @(posedge clk) begin : check_results
		page_result_t want;
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (awaited_results.size() == 0) begin
				note_mismatch("unexpected result, page", -1, int'(page_number));
			end else begin
				want = awaited_results.pop_front();
				if (page_number !== want.page)
					note_mismatch("page_number", int'(want.page), int'(page_number));
				if (status !== want.st)
					note_mismatch("status", int'(want.st), int'(status));
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		mode = MODE_ALLOC;
		page_id = '0;
		in_idle_on = 1'b1;
		out_idle_on = 1'b1;
		mismatches = 0;
		n_alloc_ok = 0;
		n_full = 0;
		n_free_ok = 0;
		n_range = 0;
		n_results = 0;
		for (int k = 0; k < MAX_PAGES_DEF / WORD_BITS_DEF; k++)
			used_map[k] = '0;
		next_hint = '0;
		page_count_m = PAGE_COUNT_RST;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		test_after_reset();
		test_count_extremes();
		test_random_traffic();

		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Checked %0d results: %0d pages allocated, %0d full, %0d freed, %0d out of range",
			n_results, n_alloc_ok, n_full, n_free_ok, n_range);
		$display("Page counts swept from zero through small values to above the bitmap size");
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
